// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bra_pkg.sv
package bra_pkg;

    // Defaults for the top-level parameters.
    localparam int TOTAL_UNITS_DEF = 4096;
    localparam int UNIT_BYTES_DEF  = 64;
    localparam int MAX_TRIES_DEF   = 16;

    // Field widths.
    localparam int REQ_W        = 18;
    localparam int ALIGN_W      = 19;
    localparam int START_UNIT_W = 12;
    localparam int ADDR_W       = 64;
    localparam int CNT_W        = 19;

    // Bitmap row width and shared divider widths.
    localparam int WORD_BITS = 64;
    localparam int DIV_N     = 32;
    localparam int DIV_D     = 19;

    localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h80200003;

    typedef struct packed {
        logic [REQ_W-1:0]   request_bytes;
        logic [ALIGN_W-1:0] align_bytes;
        logic               randomized;
    } bra_req_t;

    typedef struct packed {
        logic                    granted;
        logic [START_UNIT_W-1:0] start_unit;
        logic [ADDR_W-1:0]       start_address;
    } bra_resp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } bra_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
        logic [DIV_D-1:0] remainder;
    } bra_div_res_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_FACTOR,
        ST_BND_DIV,
        ST_BND_WAIT,
        ST_DRAW_DIV,
        ST_DRAW_WAIT,
        ST_DRAW_MUL,
        ST_RANGE,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_SET_RD,
        ST_SET_WR,
        ST_FAIL,
        ST_OFFSET,
        ST_RESULT
    } bra_state_t;

endpackage

// File: hw/rtl/bra_divider.sv
module bra_divider
    import bra_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  bra_div_req_t req,
    output bra_div_res_t res
);

    localparam int CNT_BITS = $clog2(DIV_N + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DIV_D-1:0]    rem_reg;
    logic [DIV_N-1:0]    quo_reg;
    logic [DIV_D-1:0]    div_reg;

    logic [DIV_D:0]      trial;
    logic                fits;
    logic [DIV_D:0]      diff;

    // Restoring division: the dividend shifts out of quo_reg while quotient bits shift in.
    assign trial = {rem_reg, quo_reg[DIV_N-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIV_N);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_N-2:0], fits};
            rem_reg <= fits ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// File: hw/rtl/bitmap_region_allocator.sv
// Channel   Ports                     Payload     Handshake
// request   s_valid s_ready s_data    bra_req_t   valid/ready
// result    m_valid m_ready m_data    bra_resp_t  valid/ready
// config    cfg_wr_en cfg_wr_data     region_base write only
//
// Sequential item: a reciprocal multiply gives the unit count, then each bitmap row of the
// run is read and checked, then read and marked, before the offset and the result.
// Random item: the bound comes from an iterative divider, then each try divides a new
// random draw, multiplies it out to a start and checks the rows, up to MAX_TRIES tries.
// After reset the bitmap is cleared one row per cycle (ceil(TOTAL_UNITS / WORD_BITS)
// rows, 64 at the defaults) while s_ready stays low. A stalled result waits in the
// output register; the next item is taken meanwhile and holds in ST_RESULT if needed.
`include "assert_macros.svh"

module bitmap_region_allocator
    import bra_pkg::*;
#(
    parameter int TOTAL_UNITS = TOTAL_UNITS_DEF,
    parameter int UNIT_BYTES  = UNIT_BYTES_DEF,
    parameter int MAX_TRIES   = MAX_TRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bra_req_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bra_resp_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data
);

    localparam int UNIT_W = $clog2(TOTAL_UNITS);
    localparam int ROWS   = (TOTAL_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int END_W  = ((UNIT_W > CNT_W) ? UNIT_W : CNT_W) + 1;
    localparam int TRY_W  = $clog2(MAX_TRIES + 1);
    localparam int OFF_W  = START_UNIT_W + $clog2(UNIT_BYTES + 1);
    localparam int PROD_W = 2 * DIV_D;

    // Division by UNIT_BYTES as a multiply by a rounded-up reciprocal; exact for any
    // dividend below 2^ALIGN_W.
    localparam int          RECIP_SH = ALIGN_W + $clog2(UNIT_BYTES);
    localparam logic [63:0] RECIP_M  = ((64'd1 << RECIP_SH) + 64'(UNIT_BYTES) - 64'd1)
                                       / 64'(UNIT_BYTES);
    localparam int          QPROD_W  = 2 * ALIGN_W + 2;

    bra_state_t               state_reg, state_next;
    bra_req_t                 req_reg, req_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [DIV_D-1:0]         factor_reg, factor_next;
    logic [DIV_D-1:0]         bound_reg, bound_next;
    logic [DIV_D-1:0]         rem_reg, rem_next;
    logic [UNIT_W-1:0]        first_reg, first_next;
    logic [UNIT_W-1:0]        last_reg, last_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [TRY_W-1:0]         tries_reg, tries_next;
    logic [31:0]              lfsr_reg, lfsr_next;
    logic [UNIT_W-1:0]        bump_reg, bump_next;
    logic                     granted_reg, granted_next;
    logic [OFF_W-1:0]         offset_reg, offset_next;
    logic [ADDR_W-1:0]        base_reg;
    logic                     m_valid_reg, m_valid_next;
    bra_resp_t                m_data_reg, m_data_next;

    logic [WORD_BITS-1:0]     map_mem [ROWS];
    logic [WORD_BITS-1:0]     rd_data_reg;
    logic                     mem_we;
    logic [WORD_BITS-1:0]     mem_wdata;

    bra_div_req_t             div_req;
    bra_div_res_t             div_res;

    logic [ALIGN_W-1:0]       size_seq;
    logic [ALIGN_W-1:0]       quot_src;
    logic [QPROD_W-1:0]       quot_prod;
    logic [ALIGN_W-1:0]       unit_quot;
    logic [31:0]              lfsr_step;
    logic [PROD_W-1:0]        product;
    logic [END_W-1:0]         end_sum;
    logic [ROW_W-1:0]         first_row, last_row;
    logic [BIT_W-1:0]         lo_bit, hi_bit;
    logic [WORD_BITS-1:0]     mask;
    logic [UNIT_W+START_UNIT_W-1:0] start_wide;
    logic [START_UNIT_W-1:0]  start12;

    logic                     resp_refused;
    logic                     resp_zero;
    logic                     div_wait_st;
    logic                     row_in_run;
    logic                     marking;
    logic                     drawing;

    bra_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    assign size_seq  = (ALIGN_W'(req_reg.request_bytes) < req_reg.align_bytes)
                     ? req_reg.align_bytes : ALIGN_W'(req_reg.request_bytes);
    assign quot_src  = (state_reg == ST_FACTOR) ? req_reg.align_bytes
                     : (req_reg.randomized ? ALIGN_W'(req_reg.request_bytes) : size_seq);
    assign quot_prod = QPROD_W'(quot_src) * QPROD_W'(RECIP_M);
    assign unit_quot = ALIGN_W'(quot_prod >> RECIP_SH);
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign product   = PROD_W'(rem_reg) * PROD_W'(factor_reg);
    assign end_sum   = END_W'(first_reg) + END_W'(count_reg);

    // Row-local mask of the units in [first, last] that fall into the current row.
    assign first_row = ROW_W'(first_reg / WORD_BITS);
    assign last_row  = ROW_W'(last_reg / WORD_BITS);
    assign lo_bit    = (row_reg == first_row) ? BIT_W'(first_reg % WORD_BITS) : '0;
    assign hi_bit    = (row_reg == last_row) ? BIT_W'(last_reg % WORD_BITS)
                                             : BIT_W'(WORD_BITS - 1);
    assign mask      = ({WORD_BITS{1'b1}} << lo_bit)
                     & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));

    assign start_wide = {{START_UNIT_W{1'b0}}, first_reg};
    assign start12    = start_wide[START_UNIT_W-1:0];

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        factor_next  = factor_reg;
        bound_next   = bound_reg;
        rem_next     = rem_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        row_next     = row_reg;
        tries_next   = tries_reg;
        lfsr_next    = lfsr_reg;
        bump_next    = bump_reg;
        granted_next = granted_reg;
        offset_next  = offset_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        s_ready      = 1'b0;
        div_req      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (row_reg == ROW_W'(ROWS - 1)) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                count_next = CNT_W'(unit_quot) + 1'b1;
                if (req_reg.randomized) begin
                    state_next = ST_FACTOR;
                end else begin
                    first_next = bump_reg;
                    state_next = ST_RANGE;
                end
            end
            ST_FACTOR: begin
                // An alignment below one unit counts as one unit.
                factor_next = (unit_quot == '0) ? DIV_D'(1) : DIV_D'(unit_quot);
                state_next  = ST_BND_DIV;
            end
            ST_BND_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N'(TOTAL_UNITS);
                div_req.divisor  = factor_reg;
                state_next       = ST_BND_WAIT;
            end
            ST_BND_WAIT: begin
                if (div_res.done) begin
                    // A factor larger than the region leaves unit zero as the only start.
                    bound_next = (div_res.quotient == '0) ? DIV_D'(1)
                                                          : div_res.quotient[DIV_D-1:0];
                    tries_next = '0;
                    state_next = ST_DRAW_DIV;
                end
            end
            ST_DRAW_DIV: begin
                lfsr_next        = lfsr_step;
                div_req.start    = 1'b1;
                div_req.dividend = lfsr_step;
                div_req.divisor  = bound_reg;
                state_next       = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                if (div_res.done) begin
                    rem_next   = div_res.remainder;
                    state_next = ST_DRAW_MUL;
                end
            end
            ST_DRAW_MUL: begin
                // The product stays below TOTAL_UNITS, so the part-select loses nothing.
                first_next = product[UNIT_W-1:0];
                tries_next = tries_reg + 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                if (end_sum >= END_W'(TOTAL_UNITS)) begin
                    state_next = ST_FAIL;
                end else begin
                    last_next  = UNIT_W'(end_sum - 1'b1);
                    row_next   = first_row;
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                state_next = ST_CHK_EVAL;
            end
            ST_CHK_EVAL: begin
                if ((rd_data_reg & mask) != '0) begin
                    state_next = ST_FAIL;
                end else if (row_reg == last_row) begin
                    row_next   = first_row;
                    state_next = ST_SET_RD;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_SET_RD: begin
                state_next = ST_SET_WR;
            end
            ST_SET_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg | mask;
                if (row_reg == last_row) begin
                    if (!req_reg.randomized) begin
                        bump_next = last_reg + 1'b1;
                    end
                    granted_next = 1'b1;
                    state_next   = ST_OFFSET;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_SET_RD;
                end
            end
            ST_FAIL: begin
                if (req_reg.randomized && (tries_reg != TRY_W'(MAX_TRIES))) begin
                    state_next = ST_DRAW_DIV;
                end else begin
                    granted_next = 1'b0;
                    state_next   = ST_RESULT;
                end
            end
            ST_OFFSET: begin
                offset_next = OFF_W'(start12) * OFF_W'(UNIT_BYTES);
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (granted_reg) begin
                        m_data_next.granted       = 1'b1;
                        m_data_next.start_unit    = start12;
                        m_data_next.start_address = base_reg + ADDR_W'(offset_reg);
                    end else begin
                        m_data_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            lfsr_reg    <= LFSR_SEED;
            bump_reg    <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
            granted_reg <= 1'b0;
            tries_reg   <= '0;
        end else begin
            row_reg     <= row_next;
            lfsr_reg    <= lfsr_next;
            bump_reg    <= bump_next;
            m_valid_reg <= m_valid_next;
            granted_reg <= granted_next;
            tries_reg   <= tries_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        count_reg  <= count_next;
        factor_reg <= factor_next;
        bound_reg  <= bound_next;
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        offset_reg <= offset_next;
        m_data_reg <= m_data_next;
    end

    // Bitmap: one port, the row being worked on is both read and write address.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[row_reg] <= mem_wdata;
        end
        rd_data_reg <= map_mem[row_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign resp_refused = m_valid && !m_data.granted;
    assign resp_zero    = (m_data.start_unit == '0) && (m_data.start_address == '0);
    assign div_wait_st  = (state_reg == ST_BND_WAIT) || (state_reg == ST_DRAW_WAIT);
    assign row_in_run   = (row_reg >= first_row) && (row_reg <= last_row);
    assign marking      = (state_reg == ST_SET_WR);
    assign drawing      = (state_reg == ST_DRAW_DIV);

    `ASSERT_IMPLIES(a_refused_zero, aclk, aresetn, resp_refused, resp_zero, "refused not zero")
    `ASSERT_IMPLIES(a_div_done_wait, aclk, aresetn, div_res.done, div_wait_st, "stray divide")
    `ASSERT_IMPLIES(a_set_in_run, aclk, aresetn, marking, row_in_run, "write outside run")
    `ASSERT_NEXT(a_bump_hold, aclk, aresetn, !marking, $stable(bump_reg), "bump moved")
    `ASSERT_NEXT(a_lfsr_hold, aclk, aresetn, !drawing, $stable(lfsr_reg), "random state moved")

endmodule

// File: test/bitmap_region_allocator_tb.sv
module bitmap_region_allocator_tb
    import bra_pkg::*;
();

    localparam int UNITS      = 4096;
    localparam int BYTES_PER_UNIT = 64;
    localparam int DRAW_TRIES = 16;
    localparam logic [31:0] DRAW_SEED = 32'hACE1ACE1;
    localparam logic [31:0] DRAW_TAPS = 32'h80200003;
    localparam bit MODE_BUMP   = 1'b0;
    localparam bit MODE_RANDOM = 1'b1;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    bra_req_t          s_data;
    logic              m_valid;
    logic              m_ready;
    bra_resp_t         m_data;
    logic              cfg_wr_en;
    logic [ADDR_W-1:0] cfg_wr_data;

    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    // Tracks the unit map, the bump pointer and the draw register so that each
    // accepted request yields the grant the block should return.
    class alloc_scoreboard;
        bit          taken [UNITS];
        int          next_seq_unit;
        logic [31:0] draw_state;
        logic [63:0] base_addr;
        bra_resp_t   pending_grants [$];
        int          grants;
        int          refusals;
        int          mismatches;

        function new();
            next_seq_unit = 0;
            draw_state    = DRAW_SEED;
            base_addr     = '0;
            grants        = 0;
            refusals      = 0;
            mismatches    = 0;
        endfunction

        // Marks a run as taken when it lies below the last unit and is all free.
        function bit claim_run(int first, int count);
            if (first + count >= UNITS)
                return 1'b0;
            for (int i = first; i < first + count; i++)
                if (taken[i])
                    return 1'b0;
            for (int i = first; i < first + count; i++)
                taken[i] = 1'b1;
            return 1'b1;
        endfunction

        function void note_request(bra_req_t r);
            int        req;
            int        aln;
            int        units;
            int        factor;
            int        span;
            int        first;
            bit        ok;
            bit        lsb;
            bra_resp_t g;
            req   = int'(r.request_bytes);
            aln   = int'(r.align_bytes);
            ok    = 1'b0;
            first = 0;
            if (r.randomized == MODE_BUMP) begin
                units = ((req < aln) ? aln : req) / BYTES_PER_UNIT + 1;
                first = next_seq_unit;
                ok = claim_run(first, units);
                if (ok)
                    next_seq_unit = first + units;
            end else begin
                // Random mode keeps the requested size; alignment only picks starts.
                units  = req / BYTES_PER_UNIT + 1;
                factor = aln / BYTES_PER_UNIT;
                if (factor == 0)
                    factor = 1;
                span = UNITS / factor;
                if (span == 0)
                    span = 1;
                for (int t = 0; t < DRAW_TRIES && !ok; t++) begin
                    lsb = draw_state[0];
                    draw_state = draw_state >> 1;
                    if (lsb)
                        draw_state = draw_state ^ DRAW_TAPS;
                    first = int'(draw_state % span) * factor;
                    ok = claim_run(first, units);
                end
            end
            g.granted       = ok;
            g.start_unit    = ok ? first[11:0] : '0;
            g.start_address = ok ? base_addr + {52'b0, first[11:0]} * 64'(BYTES_PER_UNIT)
                                 : '0;
            pending_grants.push_back(g);
        endfunction

        function void check_result(bra_resp_t got);
            bra_resp_t want;
            if (pending_grants.size() == 0) begin
                $error("unexpected result: granted=%0d start_unit=%0d start_address=%h",
                       got.granted, got.start_unit, got.start_address);
                mismatches++;
                return;
            end
            want = pending_grants.pop_front();
            if (got.granted !== want.granted) begin
                $error("granted: expected %0d, got %0d", want.granted, got.granted);
                mismatches++;
            end
            if (got.start_unit !== want.start_unit) begin
                $error("start_unit: expected %0d, got %0d", want.start_unit, got.start_unit);
                mismatches++;
            end
            if (got.start_address !== want.start_address) begin
                $error("start_address: expected %h, got %h",
                       want.start_address, got.start_address);
                mismatches++;
            end
            if (want.granted)
                grants++;
            else
                refusals++;
        endfunction
    endclass

    alloc_scoreboard sb = new();

    bitmap_region_allocator #(
        .TOTAL_UNITS(UNITS),
        .UNIT_BYTES (BYTES_PER_UNIT),
        .MAX_TRIES  (DRAW_TRIES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("no progress within %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic bra_req_t alloc_req(int req, int aln, bit mode);
        bra_req_t r;
        r.request_bytes = req[REQ_W-1:0];
        r.align_bytes   = aln[ALIGN_W-1:0];
        r.randomized    = mode;
        return r;
    endfunction

    // Mostly small runs so the unit map fills gradually; a few very large ones.
    function automatic bra_req_t random_request();
        bra_req_t r;
        int       pick;
        r.randomized = ($urandom_range(99) < 35) ? MODE_RANDOM : MODE_BUMP;
        pick = $urandom_range(99);
        if (pick < 80)
            r.request_bytes = REQ_W'($urandom_range(0, 255));
        else if (pick < 97)
            r.request_bytes = REQ_W'($urandom_range(0, 4095));
        else
            r.request_bytes = REQ_W'($urandom_range(0, 262143));
        pick = $urandom_range(99);
        if (pick < 35)
            r.align_bytes = '0;
        else if (pick < 70)
            r.align_bytes = ALIGN_W'(64 << $urandom_range(0, 5));
        else if (pick < 85)
            r.align_bytes = ALIGN_W'($urandom_range(0, 4095));
        else if (pick < 95)
            r.align_bytes = ALIGN_W'(64 << $urandom_range(6, 12));
        else
            r.align_bytes = ALIGN_W'($urandom_range(0, 262144));
        return r;
    endfunction

    // Called at a clock edge; returns at the edge where the item is accepted.
    task automatic send_request(input bra_req_t r);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic write_base(input logic [63:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.base_addr = v;
    endtask

    task automatic drain_grants();
        s_valid <= 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        m_ready     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_gap_pct   <= 18;
        recv_stall_pct <= 48;
        write_base('1);
        // Field extremes, unit boundaries, zero and sub-unit alignment, runs that
        // cannot fit, and random draws confined to unit zero.
        send_request(alloc_req(0, 0, MODE_BUMP));
        send_request(alloc_req(63, 0, MODE_BUMP));
        send_request(alloc_req(64, 0, MODE_BUMP));
        send_request(alloc_req(0, 63, MODE_BUMP));
        send_request(alloc_req(10, 640, MODE_BUMP));
        send_request(alloc_req(262143, 0, MODE_BUMP));
        send_request(alloc_req(0, 262144, MODE_BUMP));
        send_request(alloc_req(0, 262144, MODE_RANDOM));
        send_request(alloc_req(262143, 0, MODE_RANDOM));
        send_request(alloc_req(0, 262143, MODE_RANDOM));
        send_request(alloc_req(0, 0, MODE_RANDOM));
        send_request(alloc_req(0, 63, MODE_RANDOM));
        send_request(alloc_req(100, 100, MODE_RANDOM));
        send_request(alloc_req(100, 4096, MODE_RANDOM));
        send_request(alloc_req(0, 131072, MODE_RANDOM));
        send_request(alloc_req(0, 131072, MODE_RANDOM));
        send_request(alloc_req(1000, 0, MODE_BUMP));
        send_request(alloc_req(4095, 4160, MODE_BUMP));
        send_request(alloc_req(170000, 64, MODE_RANDOM));
        send_request(alloc_req(262143, 262144, MODE_RANDOM));
        send_request(alloc_req(131072, 0, MODE_BUMP));
        drain_grants();

        write_base({$urandom, $urandom});
        repeat (240) send_request(random_request());
        drain_grants();

        send_gap_pct   <= 48;
        recv_stall_pct <= 18;
        write_base('0);
        repeat (240) send_request(random_request());
        drain_grants();

        send_gap_pct   <= 0;
        recv_stall_pct <= 0;
        write_base(64'h8000_0000_0000_0000);
        repeat (230) send_request(random_request());
        drain_grants();

        // Give a stray late result time to show up.
        repeat (500) @(posedge aclk);
        $display("checked %0d allocation results: %0d granted, %0d refused",
                 sb.grants + sb.refusals, sb.grants, sb.refusals);
        $display("base moved through all-ones, random, zero and top-bit values under mixed stalls");
        if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
